[rtl/core/shcl_pkg.sv]
`timescale 1ns / 1ps
package shcl_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned HashWords  = 8;
  localparam int unsigned Rounds     = 64;

  // Chain head after reset: SHA-256 of 64 zero bytes.
  localparam logic [255:0] GenesisHash =
    256'hf5a5fd42d16a20302798ef6ed309979b43003d2320d9f0e8ea9831a92759fb4b;

  localparam logic [255:0] InitialH =
    256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_WAIT,
    ST_PAD,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } comp_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

endpackage

[rtl/core/shcl_if.sv]
`timescale 1ns / 1ps
interface shcl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_source;
  logic [63:0] tick_now;
  logic [7:0]  payload_byte;
  logic        byte_present;
  logic        end_of_event;
  modport source (output valid, event_source, tick_now, payload_byte, byte_present,
                  end_of_event, input ready);
  modport sink (input valid, event_source, tick_now, payload_byte, byte_present,
                end_of_event, output ready);
endinterface

interface shcl_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] link_seq;
  logic [63:0] link_time;
  logic [31:0] link_source;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, link_seq, link_time, link_source, digest_word,
                  word_index, last_word, input ready);
  modport sink (input valid, link_seq, link_time, link_source, digest_word,
                word_index, last_word, output ready);
endinterface

interface shcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/core/shcl_compress.sv]
`timescale 1ns / 1ps
// One SHA-256 round per cycle; message schedule in a 16-word sliding window.
module shcl_compress (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [511:0]           block,
  input  logic [255:0]           h_in,
  output logic [255:0]           h_out,
  output logic                   busy
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] h [8];
  logic [5:0]  rnd;
  logic [31:0] w_new, s0, s1, e1, ch, a0, maj, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    e1    = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + e1 + ch + shcl_pkg::round_k(rnd) + w[0];
    a0    = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = a0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rnd  <= '0;
    end else if (busy) begin
      rnd <= rnd + 6'd1;
      if (rnd == 6'(shcl_pkg::Rounds - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) begin
        v[i] <= h_in[255 - 32*i -: 32];
        h[i] <= h_in[255 - 32*i -: 32];
      end
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      if (rnd == 6'(shcl_pkg::Rounds - 1)) begin
        h[7] <= h[7] + v[6]; h[6] <= h[6] + v[5]; h[5] <= h[5] + v[4];
        h[4] <= h[4] + v[3] + t1; h[3] <= h[3] + v[2]; h[2] <= h[2] + v[1];
        h[1] <= h[1] + v[0]; h[0] <= h[0] + t1 + t2;
      end
    end
  end

  assign h_out = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("compress restarted while busy");
  a_round_zero: assert property (@(posedge clk) disable iff (rst) start |=> rnd == 6'd0)
    else $error("round counter not cleared");
  a_done: assert property (@(posedge clk) disable iff (rst)
      (busy && rnd == 6'd63) |=> !busy)
    else $error("compress overran");
`endif

endmodule

[rtl/core/sha256_hash_chain_logger.sv]
`timescale 1ns / 1ps
// Operation: the first request of an event writes the 52 header bytes, compressing each
//   full 64-byte block; each payload byte is written, with a compression when it fills a block.
// Final request: 1-2 padding compressions, then 4 results.
// Throughput: one request at a time; the single round-per-cycle compress unit sets it.
// Reset: synchronous; chain head returns to genesis, sequence and boot tick to zero.
module sha256_hash_chain_logger (
  input  logic clk,
  input  logic rst,
  shcl_in_if.sink    in_req,
  shcl_out_if.source out_res,
  shcl_cfg_if.sink   cfg
);

  shcl_pkg::state_t state, state_next;

  logic [63:0]  boot_tick;
  logic [255:0] chain_hash;
  logic [63:0]  link_counter;
  logic [255:0] digest_state;
  logic [511:0] block_buffer;   // byte 0 in the top bits
  logic [63:0]  message_length;
  logic [63:0]  held_time;
  logic [31:0]  held_source;
  logic         in_event;
  logic         pend_byte, pend_end;
  logic [7:0]   pend_data;
  logic [5:0]   hdr_cnt;
  logic         second_pad;     // a second padding block is still to come
  logic [1:0]   out_idx;
  logic         comp_started;

  // Header stream: 32 bytes chain (big-endian), seq, time, source little-endian.
  logic [63:0]  seq_next;
  logic [415:0] hdr_bytes;
  logic [7:0]   hdr_byte;
  logic [7:0]   cur_byte;
  logic         do_write;
  logic [5:0]   pos;
  logic         fills;

  shcl_pkg::comp_ctl_t comp;
  logic [511:0] comp_block;
  logic [255:0] comp_h;

  function automatic logic [63:0] bswap64(input logic [63:0] x);
    logic [63:0] r;
    begin
      for (int i = 0; i < 8; i++) r[8*i +: 8] = x[63 - 8*i -: 8];
      return r;
    end
  endfunction

  assign seq_next = link_counter + 64'd1;
  assign hdr_bytes = {chain_hash, bswap64(seq_next), bswap64(held_time),
                      held_source[7:0], held_source[15:8], held_source[23:16],
                      held_source[31:24]};
  assign hdr_byte = hdr_bytes[415 - 8*hdr_cnt -: 8];
  assign pos      = message_length[5:0];
  assign cur_byte = (state == shcl_pkg::ST_HDR) ? hdr_byte : pend_data;
  assign fills    = (pos == 6'd63);

  assign in_req.ready = (state == shcl_pkg::ST_IDLE);
  assign cfg.ready    = 1'b1;

  always_comb begin
    do_write = 1'b0;
    if (state == shcl_pkg::ST_HDR) do_write = 1'b1;
    if (state == shcl_pkg::ST_WAIT && !comp.busy && !comp_started && pend_byte) do_write = 1'b1;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      shcl_pkg::ST_IDLE: if (in_req.valid)
        state_next = in_event ? shcl_pkg::ST_WAIT : shcl_pkg::ST_HDR;
      shcl_pkg::ST_HDR: if (hdr_cnt == 6'd51 || fills) state_next = shcl_pkg::ST_WAIT;
      shcl_pkg::ST_WAIT: begin
        if (!comp.busy && !comp_started) begin
          if (hdr_cnt != 6'd52 && hdr_cnt != 6'd0) state_next = shcl_pkg::ST_HDR;
          else if (pend_byte) state_next = fills ? shcl_pkg::ST_WAIT :
                                   (pend_end ? shcl_pkg::ST_PAD : shcl_pkg::ST_IDLE);
          else state_next = pend_end ? shcl_pkg::ST_PAD : shcl_pkg::ST_IDLE;
        end
      end
      shcl_pkg::ST_PAD: state_next = shcl_pkg::ST_FIN;
      shcl_pkg::ST_FIN: if (!comp.busy && !comp_started)
        state_next = second_pad ? shcl_pkg::ST_FIN : shcl_pkg::ST_OUT;
      shcl_pkg::ST_OUT: if (out_res.ready && out_idx == 2'd3) state_next = shcl_pkg::ST_IDLE;
      default: state_next = shcl_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    comp.start = 1'b0;
    comp_block = block_buffer;
    if (state == shcl_pkg::ST_HDR && fills) comp.start = 1'b0;
    if ((state == shcl_pkg::ST_WAIT || state == shcl_pkg::ST_FIN) && comp_started)
      comp.start = 1'b1;
    out_res.valid       = (state == shcl_pkg::ST_OUT);
    out_res.link_seq    = link_counter;
    out_res.link_time   = held_time;
    out_res.link_source = held_source;
    out_res.digest_word = chain_hash[255 - 64*out_idx -: 64];
    out_res.word_index  = out_idx;
    out_res.last_word   = (out_idx == 2'd3);
  end

  assign comp_h = digest_state;

  shcl_compress u_comp (
    .clk   (clk),
    .rst   (rst),
    .start (comp.start),
    .block (comp_block),
    .h_in  (comp_h),
    .h_out (),
    .busy  (comp.busy)
  );

  // Feedback of compress result goes through a second view of its output.
  logic [255:0] comp_out;
  assign comp_out = u_comp.h_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= shcl_pkg::ST_IDLE;
      boot_tick    <= '0;
      chain_hash   <= shcl_pkg::GenesisHash;
      link_counter <= '0;
      in_event     <= 1'b0;
      held_time    <= '0;
      held_source  <= '0;
      message_length <= '0;
      hdr_cnt      <= '0;
      out_idx      <= '0;
      comp_started <= 1'b0;
      second_pad   <= 1'b0;
      pend_byte    <= 1'b0;
      pend_end     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) boot_tick <= cfg.data;
      comp_started <= 1'b0;
      if (comp_started) digest_state <= digest_state;
      if (state == shcl_pkg::ST_IDLE && in_req.valid) begin
        pend_byte <= in_req.byte_present;
        pend_end  <= in_req.end_of_event;
        pend_data <= in_req.payload_byte;
        hdr_cnt   <= in_event ? 6'd52 : 6'd0;
        if (!in_event) begin
          held_source    <= in_req.event_source;
          held_time      <= in_req.tick_now - boot_tick;
          digest_state   <= shcl_pkg::InitialH;
          message_length <= '0;
          in_event       <= 1'b1;
        end
      end
      if (do_write) begin
        block_buffer[511 - 8*pos -: 8] <= cur_byte;
        message_length <= message_length + 64'd1;
        if (state == shcl_pkg::ST_HDR) hdr_cnt <= hdr_cnt + 6'd1;
        else pend_byte <= 1'b0;
        if (fills) comp_started <= 1'b1;
      end
      if (state == shcl_pkg::ST_WAIT && comp.busy && u_comp.rnd == 6'd63)
        digest_state <= digest_state;
      if (state == shcl_pkg::ST_PAD) begin
        block_buffer[511 - 8*pos -: 8] <= 8'h80;
        for (int i = 0; i < 64; i++)
          if (6'(i) > pos) block_buffer[511 - 8*i -: 8] <= 8'h00;
        if (pos < 6'd56) begin
          block_buffer[63:0] <= {message_length[60:0], 3'b000};
          second_pad <= 1'b0;
        end else begin
          second_pad <= 1'b1;
        end
        comp_started <= 1'b1;
      end
      if (state == shcl_pkg::ST_FIN && !comp.busy && !comp_started && second_pad) begin
        block_buffer <= {448'd0, message_length[60:0], 3'b000};
        second_pad   <= 1'b0;
        comp_started <= 1'b1;
      end
      if (state == shcl_pkg::ST_FIN && state_next == shcl_pkg::ST_OUT) begin
        chain_hash   <= comp_out;
        link_counter <= seq_next;
        in_event     <= 1'b0;
        out_idx      <= '0;
      end
      if (state == shcl_pkg::ST_OUT && out_res.ready) out_idx <= out_idx + 2'd1;
      // Latch compress result into the running state once a block finishes.
      if (comp.busy && u_comp.rnd == 6'd63) digest_state <= digest_state;
      if (!comp.busy && !comp_started && $past(comp.busy)) digest_state <= comp_out;
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
      in_req.ready |-> state == shcl_pkg::ST_IDLE)
    else $error("ready outside idle");
  a_out_only: assert property (@(posedge clk) disable iff (rst)
      out_res.valid |-> !comp.busy)
    else $error("result shown while hashing");
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
      (out_res.valid && out_res.ready && out_res.last_word) |=> !in_event)
    else $error("event not closed");
`endif

endmodule

[test/shcl_tb_if.sv]
`timescale 1ns / 1ps
// The channel interfaces are defined with the RTL in rtl/core/shcl_if.sv.
// The testbench uses them as they stand, so this file declares nothing.

[test/sha256_hash_chain_logger_tb.sv]
`timescale 1ns / 1ps
module sha256_hash_chain_logger_tb;
  import shcl_pkg::*;

  typedef struct {
    logic [63:0] seq;
    logic [63:0] tstamp;
    logic [31:0] src;
    logic [63:0] word;
    logic [1:0]  idx;
    logic        last;
  } link_word_t;

  // Round constants, kept locally so the package function is not reused.
  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Chain predictor: running SHA-256 over header and payload, one byte at a time.
  class chain_scoreboard;
    logic [63:0]  boot_tick;
    logic [255:0] head;
    logic [63:0]  seq_no;
    logic [31:0]  h[8];
    logic [7:0]   blk[64];
    logic [63:0]  msg_len;
    logic [63:0]  tstamp;
    logic [31:0]  src;
    bit           open_event;
    link_word_t   pending[$];
    int           errors;

    function void reset_chain();
      boot_tick = '0; head = GenesisHash; seq_no = '0; msg_len = '0;
      open_event = 0; pending.delete();
    endfunction

    function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + w[i-7]
             + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = h[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) h[i] += v[i];
    endfunction

    function void add_byte(logic [7:0] b);
      blk[msg_len[5:0]] = b;
      msg_len++;
      if (msg_len[5:0] == 0) compress();
    endfunction

    function void add_le(logic [63:0] x, int n);
      for (int i = 0; i < n; i++) add_byte(x[8*i +: 8]);
    endfunction

    function void note_request(logic [31:0] es, logic [63:0] tk, logic [7:0] pb,
                               logic bp, logic eoe);
      int pos;
      logic [63:0] bits;
      if (!open_event) begin
        src = es; tstamp = tk - boot_tick;
        for (int i = 0; i < 8; i++) h[i] = InitialH[255 - 32*i -: 32];
        msg_len = '0;
        for (int i = 0; i < 32; i++) add_byte(head[255 - 8*i -: 8]);
        add_le(seq_no + 64'd1, 8);
        add_le(tstamp, 8);
        add_le({32'd0, src}, 4);
        open_event = 1;
      end
      if (bp) add_byte(pb);
      if (!eoe) return;
      pos = msg_len[5:0];
      bits = msg_len << 3;
      blk[pos++] = 8'h80;
      if (pos > 56) begin
        while (pos < 64) blk[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < 56) blk[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) head[255 - 32*i -: 32] = h[i];
      seq_no++;
      open_event = 0;
      for (int k = 0; k < 4; k++)
        pending.push_back('{seq_no, tstamp, src, head[255 - 64*k -: 64], k[1:0], k == 3});
    endfunction

    function void check_result(link_word_t got);
      link_word_t exp;
      if (pending.size() == 0) begin
        $error("unexpected link word, seq %0h", got.seq);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.seq !== exp.seq) begin
        $error("link_seq exp %0h got %0h", exp.seq, got.seq); errors++;
      end
      if (got.tstamp !== exp.tstamp) begin
        $error("link_time exp %0h got %0h", exp.tstamp, got.tstamp); errors++;
      end
      if (got.src !== exp.src) begin
        $error("link_source exp %0h got %0h", exp.src, got.src); errors++;
      end
      if (got.word !== exp.word) begin
        $error("digest_word exp %0h got %0h", exp.word, got.word); errors++;
      end
      if (got.idx !== exp.idx) begin
        $error("word_index exp %0d got %0d", exp.idx, got.idx); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_word exp %0d got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  shcl_in_if  in_req();
  shcl_out_if out_res();
  shcl_cfg_if cfg();

  sha256_hash_chain_logger u_top (
    .clk(clk), .rst(rst), .in_req(in_req), .out_res(out_res), .cfg(cfg)
  );

  chain_scoreboard sb = new();

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver stall control: random pattern, a long hold-off on request.
  int  stall_pct = 30;
  bit  hold_off = 0;
  int  idle_cycles = 0;
  bit  timed_out = 0;

  initial begin
    out_res.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off || rst)
        out_res.ready <= 0;
      else
        out_res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Accept monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_res.valid && out_res.ready)
        sb.check_result('{out_res.link_seq, out_res.link_time, out_res.link_source,
                          out_res.digest_word, out_res.word_index, out_res.last_word});
      if ((out_res.valid && out_res.ready) || (in_req.valid && in_req.ready) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Worst event: 52 header bytes, several full blocks, two pad blocks.
  initial begin
    wait (idle_cycles >= 5000);
    $display("sha256_hash_chain_logger: mismatch");
    $finish;
  end

  // Longest gap between bursts; zero gives back-to-back requests.
  int burst_left = 0;
  int gap_max = 3;

  task automatic send_request(logic [31:0] es, logic [63:0] tk, logic [7:0] pb,
                              logic bp, logic eoe);
    if (burst_left == 0) begin
      in_req.valid <= 0;
      repeat ($urandom_range(gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_req.valid        <= 1;
    in_req.event_source <= es;
    in_req.tick_now     <= tk;
    in_req.payload_byte <= pb;
    in_req.byte_present <= bp;
    in_req.end_of_event <= eoe;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(es, tk, pb, bp, eoe);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_req.valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // a non-final request may still be hashing a block
    repeat (300) @(posedge clk);
  endtask

  task automatic write_boot_tick(logic [63:0] v);
    cfg.valid <= 1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    sb.boot_tick = v;
  endtask

  // One event with n payload bytes; optional no-byte items mixed in.
  task automatic send_event(logic [31:0] es, logic [63:0] tk, int n, bit holes);
    logic [7:0] b;
    if (n == 0) begin
      send_request(es, tk, $urandom, 0, 1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      b = $urandom;
      if (holes && $urandom_range(3) == 0)
        send_request($urandom, {$urandom, $urandom}, $urandom, 0, 0);
      send_request((i == 0) ? es : $urandom, (i == 0) ? tk : {$urandom, $urandom},
                   b, 1, i == n - 1);
    end
  endtask

  task automatic random_event();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 12);
    send_event($urandom, {$urandom, $urandom}, n, $urandom_range(1));
  endtask

  initial begin
    in_req.valid = 0; in_req.event_source = '0; in_req.tick_now = '0;
    in_req.payload_byte = '0; in_req.byte_present = 0; in_req.end_of_event = 0;
    cfg.valid = 0; cfg.data = '0;
    sb.reset_chain();
    sb.errors = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty payload, field extremes, no-byte items, later-item fields ignored.
    send_event(32'h0, 64'h0, 0, 0);
    send_event(32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1, 0);
    send_request(32'h1234_5678, 64'h10, 8'hff, 1, 0);
    send_request(32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'h00, 0, 0);
    send_request(32'h0, 64'h0, 8'h00, 1, 0);
    send_request(32'h0, 64'h0, 8'haa, 0, 1);
    send_event(32'h5555_aaaa, 64'h8000_0000_0000_0000, 3, 0);
    send_event(32'haaaa_5555, 64'h7fff_ffff_ffff_ffff, 12, 0);  // 64 bytes: pad fits next block
    send_event(32'h1, 64'h1, 4, 0);                           // 56 bytes: two pad blocks
    wait_drained();

    // Boot tick at its maximum: timestamps wrap.
    write_boot_tick(64'hffff_ffff_ffff_ffff);
    send_event(32'h0, 64'h0, 0, 0);
    send_event(32'h2, 64'hffff_ffff_ffff_fffe, 2, 1);
    wait_drained();
    write_boot_tick(64'h0);

    // Random phases with changing boot tick and idling styles.
    for (int ph = 0; ph < 4; ph++) begin
      stall_pct = (ph == 2) ? 0 : $urandom_range(10, 70);
      gap_max = (ph == 1) ? 0 : 4;
      for (int e = 0; e < 6; e++) random_event();
      if (ph == 1) begin
        // long receiver hold-off while requests keep coming
        hold_off = 1;
        fork
          begin
            repeat (1500) @(posedge clk);
            hold_off = 0;
          end
          for (int e = 0; e < 4; e++) random_event();
        join
      end
      wait_drained();
      write_boot_tick({$urandom, $urandom});
    end
    wait_drained();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("sha256_hash_chain_logger: match");
    else
      $display("sha256_hash_chain_logger: mismatch");
    $finish;
  end
endmodule
